### rtl/mdps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared codes, types and arithmetic helpers for the masked plane smoother.
// ----------------------------------------------------------------------------
package mdps_pkg;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // register indexes
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_HQ     = 3'd3;
   localparam logic [2:0] REG_STR    = 3'd4;
   localparam logic [2:0] REG_SHOW   = 3'd5;

   // plane memory codes
   localparam logic [2:0] MEM_SRC  = 3'd0;
   localparam logic [2:0] MEM_SCR  = 3'd1;
   localparam logic [2:0] MEM_BLR  = 3'd2;
   localparam logic [2:0] MEM_MSK  = 3'd3;
   localparam logic [2:0] MEM_PING = 3'd4;
   localparam logic [2:0] MEM_PONG = 3'd5;

   // sequencer phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_BLUR1 = 3'd1;
   localparam logic [2:0] PH_BLUR2 = 3'd2;
   localparam logic [2:0] PH_MASK  = 3'd3;
   localparam logic [2:0] PH_EDGE  = 3'd4;
   localparam logic [2:0] PH_VERT  = 3'd5;
   localparam logic [2:0] PH_HORZ  = 3'd6;

   // per-plane write enables
   typedef struct packed {
      logic src;
      logic scr;
      logic blr;
      logic msk;
      logic ping;
      logic pong;
   } mdps_wen_type;

   // floor(s/3) for s up to 765 by reciprocal multiply
   function automatic logic [7:0] div3(input logic [9:0] s);
      logic [19:0] p;
      p = 20'(s) * 20'd683;
      return p[18:11];
   endfunction

   // average of one to three samples, truncated
   function automatic logic [7:0] avg(input logic [9:0] s, input logic [1:0] cnt);
      logic [7:0] r;
      case (cnt)
         2'd1:    r = s[7:0];
         2'd2:    r = s[8:1];
         default: r = div3(s);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] adiff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage
`default_nettype wire

### rtl/mdps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdps_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mdps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/mdps_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdps_engine
// Run sequencer: walks the planes pixel by pixel, gathers neighbor taps from
// the plane memories one read per cycle, then writes at most one result per pixel.
// ----------------------------------------------------------------------------
module mdps_engine #(
   parameter int CW = 9,
   parameter int RW = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [CW:0]           w_eff,
   input  wire logic [RW:0]           h_eff,
   input  wire logic [7:0]            thresh,
   input  wire logic                  hq,
   input  wire logic [6:0]            n_pass,
   input  wire logic [7:0]            src_rd,
   input  wire logic [7:0]            scr_rd,
   input  wire logic [7:0]            blr_rd,
   input  wire logic                  msk_rd,
   input  wire logic [7:0]            ping_rd,
   input  wire logic [7:0]            pong_rd,
   output logic      [RW+CW-1:0]      rd_addr,
   output logic      [RW+CW-1:0]      wr_addr,
   output logic      [7:0]            wr_data,
   output mdps_pkg::mdps_wen_type     wen,
   output logic                      done
);
   import mdps_pkg::*;

   logic [2:0]    phase_ff, phase_in;
   logic [3:0]    step_ff, step_in;
   logic [CW-1:0] x_ff, x_in;
   logic [RW-1:0] y_ff, y_in;
   logic [6:0]    pass_ff, pass_in;
   logic [2:0]    in_mem_ff, in_mem_in;
   logic [2:0]    out_mem_ff, out_mem_in;
   logic [2:0]    rd_mem_ff;
   logic [7:0]    dat_ff [0:6];

   logic [2:0]        tap_mem;
   logic signed [1:0] tap_dy, tap_dx;
   logic [3:0]        n_reads;
   logic [RW-1:0]     ry;
   logic [CW-1:0]     rx;
   logic [7:0]        rd_sel;
   logic              bord, last_x, last_y, wr_step, cap_step;
   logic [2:0]        cap_idx;
   logic              m_hit;
   logic [9:0]        sum;
   logic [1:0]        cnt;
   logic [7:0]        val;

   // tap list for the current phase and step
   always_comb begin
      tap_mem = MEM_SRC;
      tap_dy  = 2'sd0;
      tap_dx  = 2'sd0;
      n_reads = 4'd1;
      case (phase_ff)
         PH_BLUR1, PH_BLUR2: begin
            n_reads = 4'd3;
            tap_mem = (phase_ff == PH_BLUR1) ? MEM_SRC : MEM_SCR;
            tap_dy  = (step_ff == 4'd0) ? -2'sd1 : ((step_ff == 4'd1) ? 2'sd0 : 2'sd1);
         end
         PH_MASK: begin
            n_reads = 4'd7;
            case (step_ff)
               4'd0: tap_mem = MEM_SCR;
               4'd1: begin tap_mem = MEM_SCR; tap_dy = 2'sd1; tap_dx = 2'sd1; end
               4'd2: begin tap_mem = MEM_SCR; tap_dx = 2'sd1; end
               4'd3: begin tap_mem = MEM_SCR; tap_dy = 2'sd1; end
               4'd4: tap_mem = MEM_BLR;
               4'd5: begin tap_mem = MEM_BLR; tap_dy = 2'sd1; end
               default: begin tap_mem = MEM_BLR; tap_dx = 2'sd1; end
            endcase
         end
         PH_EDGE: begin
            n_reads = 4'd1;
            tap_mem = MEM_SRC;
         end
         PH_VERT: begin
            n_reads = 4'd6;
            case (step_ff)
               4'd0: tap_mem = MEM_MSK;
               4'd1: begin tap_mem = MEM_MSK; tap_dy = -2'sd1; end
               4'd2: begin tap_mem = MEM_MSK; tap_dy = 2'sd1; end
               4'd3: begin tap_mem = in_mem_ff; tap_dy = -2'sd1; end
               4'd4: tap_mem = in_mem_ff;
               default: begin tap_mem = in_mem_ff; tap_dy = 2'sd1; end
            endcase
         end
         PH_HORZ: begin
            n_reads = 4'd7;
            case (step_ff)
               4'd0: tap_mem = MEM_MSK;
               4'd1: begin tap_mem = MEM_MSK; tap_dx = -2'sd1; end
               4'd2: begin tap_mem = MEM_MSK; tap_dx = 2'sd1; end
               4'd3: begin tap_mem = MEM_SCR; tap_dx = -2'sd1; end
               4'd4: tap_mem = MEM_SCR;
               4'd5: begin tap_mem = MEM_SCR; tap_dx = 2'sd1; end
               default: tap_mem = in_mem_ff;
            endcase
         end
         default: n_reads = 4'd1;
      endcase
   end

   // read address and capture select
   assign ry       = y_ff + RW'(tap_dy);
   assign rx       = x_ff + CW'(tap_dx);
   assign rd_addr  = {ry, rx};
   assign cap_step = (step_ff != 4'd0) && (step_ff <= n_reads);
   assign cap_idx  = 3'(step_ff - 4'd1);
   assign wr_step  = (phase_ff != PH_IDLE) && (step_ff == n_reads + 4'd1);

   always_comb begin
      case (rd_mem_ff)
         MEM_SRC:  rd_sel = src_rd;
         MEM_SCR:  rd_sel = scr_rd;
         MEM_BLR:  rd_sel = blr_rd;
         MEM_MSK:  rd_sel = {7'd0, msk_rd};
         MEM_PING: rd_sel = ping_rd;
         default:  rd_sel = pong_rd;
      endcase
   end

   // pixel position flags
   assign last_x = ({1'b0, x_ff} == w_eff - 1'b1);
   assign last_y = ({1'b0, y_ff} == h_eff - 1'b1);
   assign bord   = (x_ff == '0) || (y_ff == '0) || last_x || last_y;

   // detail test and smoothing sums
   assign m_hit = bord
      || (adiff(dat_ff[0], dat_ff[1]) >= thresh)
      || (adiff(dat_ff[2], dat_ff[3]) >= thresh)
      || (hq && ((adiff(dat_ff[4], dat_ff[5]) >= thresh)
              || (adiff(dat_ff[4], dat_ff[6]) >= thresh)));

   always_comb begin
      if (phase_ff == PH_VERT) begin
         sum = {2'd0, dat_ff[4]}
             + (dat_ff[1][0] ? 10'd0 : {2'd0, dat_ff[3]})
             + (dat_ff[2][0] ? 10'd0 : {2'd0, dat_ff[5]});
      end else begin
         sum = {2'd0, dat_ff[4]}
             + (dat_ff[1][0] ? 10'd0 : {2'd0, dat_ff[3]})
             + (dat_ff[2][0] ? 10'd0 : {2'd0, dat_ff[5]});
      end
      cnt = 2'd1 + {1'b0, ~dat_ff[1][0]} + {1'b0, ~dat_ff[2][0]};
   end

   // write value and enables
   always_comb begin
      wen = '0;
      val = dat_ff[0];
      case (phase_ff)
         PH_BLUR1, PH_BLUR2: begin
            val = bord ? dat_ff[1]
                       : div3({2'd0, dat_ff[0]} + {2'd0, dat_ff[1]} + {2'd0, dat_ff[2]});
            wen.scr = wr_step && (phase_ff == PH_BLUR1);
            wen.blr = wr_step && (phase_ff == PH_BLUR2);
         end
         PH_MASK: begin
            val     = {7'd0, m_hit};
            wen.msk = wr_step;
         end
         PH_EDGE: begin
            val      = dat_ff[0];
            wen.ping = wr_step && bord;
            wen.pong = wr_step && bord;
         end
         PH_VERT: begin
            val     = (bord || dat_ff[0][0]) ? dat_ff[4] : avg(sum, cnt);
            wen.scr = wr_step;
         end
         PH_HORZ: begin
            val      = dat_ff[0][0] ? dat_ff[6] : avg(sum, cnt);
            wen.ping = wr_step && !bord && (out_mem_ff == MEM_PING);
            wen.pong = wr_step && !bord && (out_mem_ff == MEM_PONG);
         end
         default: wen = '0;
      endcase
   end

   assign wr_addr = {y_ff, x_ff};
   assign wr_data = val;

   // scan and phase sequencing
   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      pass_in    = pass_ff;
      in_mem_in  = in_mem_ff;
      out_mem_in = out_mem_ff;
      done       = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start) begin
            phase_in = PH_BLUR1;
            step_in  = '0;
            x_in     = '0;
            y_in     = '0;
         end
      end else if (!wr_step) begin
         step_in = step_ff + 4'd1;
      end else begin
         step_in = '0;
         if (!last_x) begin
            x_in = x_ff + 1'b1;
         end else begin
            x_in = '0;
            if (!last_y) begin
               y_in = y_ff + 1'b1;
            end else begin
               y_in = '0;
               unique case (phase_ff)
                  PH_BLUR1: phase_in = PH_BLUR2;
                  PH_BLUR2: phase_in = PH_MASK;
                  PH_MASK:  phase_in = PH_EDGE;
                  PH_EDGE: begin
                     phase_in   = PH_VERT;
                     pass_in    = '0;
                     in_mem_in  = MEM_SRC;
                     out_mem_in = MEM_PING;
                  end
                  PH_VERT:  phase_in = PH_HORZ;
                  PH_HORZ: begin
                     if (pass_ff + 7'd1 < n_pass) begin
                        phase_in   = PH_VERT;
                        pass_in    = pass_ff + 7'd1;
                        in_mem_in  = out_mem_ff;
                        out_mem_in = (out_mem_ff == MEM_PING) ? MEM_PONG : MEM_PING;
                     end else begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // position, pass and tap data
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      pass_ff    <= pass_in;
      in_mem_ff  <= in_mem_in;
      out_mem_ff <= out_mem_in;
      rd_mem_ff  <= tap_mem;
      if (cap_step) begin
         dat_ff[cap_idx] <= rd_sel;
      end
   end

endmodule
`default_nettype wire

### rtl/detail_masked_plane_smoother.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detail_masked_plane_smoother
// Loads an 8-bit plane, builds a detail mask and applies masked smoothing.
// ----------------------------------------------------------------------------
// Load: one beat per cycle while idle with no response pending; no response. Read:
// the response is registered after the read state, next request taken once it is gone.
// Run: two blur phases, a mask phase, an edge phase, then s = max(1,strength)
// smoothing passes; each pixel reads its neighbor taps one by one on the shared memory read bus.
// Reset (synchronous) restores register defaults and selects the ping plane;
// plane memories are not cleared and hold undefined data until written.
module detail_masked_plane_smoother #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // mode[1:0], col[10:2], row[19:11], pixel[27:20]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // pixel_out[7:0], status[8]
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_wr_data
);
   import mdps_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [9:0] width_ff, height_ff;
   logic [7:0] thresh_ff;
   logic       hq_ff, show_ff, sel_ff, sel_in;
   logic [6:0] str_ff;
   logic [1:0] st_ff, st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pix_ff, rsp_pix_in;
   logic       rsp_stat_ff, rsp_stat_in;
   logic       rd_ok_ff, rd_mask_ff;

   logic [1:0]    req_mode;
   logic [8:0]    req_col, req_row;
   logic [7:0]    req_pixel;
   logic          accept, load_we, rd_ok, eng_start, eng_done;
   logic [CW:0]   w_eff;
   logic [RW:0]   h_eff;
   logic [6:0]    n_pass;
   logic [AW-1:0] req_addr, eng_rd_addr, eng_wr_addr, rd_addr, wr_addr;
   logic [7:0]    eng_wr_data, wr_data;
   mdps_wen_type  eng_wen;
   logic [7:0]    src_rd, scr_rd, blr_rd, ping_rd, pong_rd;
   logic          msk_rd;

   // request fields
   assign req_mode  = req_tdata[1:0];
   assign req_col   = req_tdata[10:2];
   assign req_row   = req_tdata[19:11];
   assign req_pixel = req_tdata[27:20];
   assign req_addr  = {RW'(req_row), CW'(req_col)};

   // effective plane size and pass count
   always_comb begin
      if (width_ff < 10'd3)                 w_eff = (CW+1)'(3);
      else if (32'(width_ff) > MAX_WIDTH)   w_eff = (CW+1)'(MAX_WIDTH);
      else                                  w_eff = (CW+1)'(width_ff);
      if (height_ff < 10'd3)                h_eff = (RW+1)'(3);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
      else                                  h_eff = (RW+1)'(height_ff);
      n_pass = (str_ff == 7'd0) ? 7'd1 : str_ff;
   end

   assign req_tready = (st_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign load_we    = accept && (req_mode == MODE_LOAD)
                    && (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign eng_start  = accept && (req_mode == MODE_RUN);
   assign rd_ok      = (32'(req_col) < 32'(w_eff)) && (32'(req_row) < 32'(h_eff));

   // shared memory buses
   assign rd_addr = (st_ff == ST_RUN) ? eng_rd_addr : req_addr;
   assign wr_addr = (st_ff == ST_RUN) ? eng_wr_addr : req_addr;
   assign wr_data = (st_ff == ST_RUN) ? eng_wr_data : req_pixel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd512;
         height_ff <= 10'd512;
         thresh_ff <= 8'd15;
         hq_ff     <= 1'b1;
         str_ff    <= 7'd3;
         show_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wr_data;
            REG_HEIGHT: height_ff <= csr_wr_data;
            REG_THRESH: thresh_ff <= csr_wr_data[7:0];
            REG_HQ:     hq_ff     <= csr_wr_data[0];
            REG_STR:    str_ff    <= csr_wr_data[6:0];
            REG_SHOW:   show_ff   <= csr_wr_data[0];
            default:    ;
         endcase
      end
   end

   // control sequencing and response register
   always_comb begin
      st_in        = st_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_stat_in  = rsp_stat_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_READ) st_in = ST_READ;
            if (eng_start)                       st_in = ST_RUN;
         end
         ST_READ: begin
            st_in        = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_stat_in  = 1'b0;
            if (!rd_ok_ff)       rsp_pix_in = 8'd0;
            else if (rd_mask_ff) rsp_pix_in = msk_rd ? 8'hff : 8'd0;
            else                 rsp_pix_in = sel_ff ? pong_rd : ping_rd;
         end
         ST_RUN: begin
            if (eng_done) begin
               st_in        = ST_IDLE;
               sel_in       = ~n_pass[0];
               rsp_valid_in = 1'b1;
               rsp_pix_in   = 8'd0;
               rsp_stat_in  = 1'b1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      rsp_stat_ff <= rsp_stat_in;
      if (accept) begin
         rd_ok_ff   <= rd_ok;
         rd_mask_ff <= show_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_stat_ff, rsp_pix_ff};

   // run sequencer
   mdps_engine #(
      .CW (CW),
      .RW (RW)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (eng_start),
      .w_eff   (w_eff),
      .h_eff   (h_eff),
      .thresh  (thresh_ff),
      .hq      (hq_ff),
      .n_pass  (n_pass),
      .src_rd  (src_rd),
      .scr_rd  (scr_rd),
      .blr_rd  (blr_rd),
      .msk_rd  (msk_rd),
      .ping_rd (ping_rd),
      .pong_rd (pong_rd),
      .rd_addr (eng_rd_addr),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data),
      .wen     (eng_wen),
      .done    (eng_done)
   );

   // plane memories
   mdps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_src (
      .clock (clock), .wr_en (load_we | eng_wen.src), .wr_addr (wr_addr),
      .wr_data (wr_data), .rd_addr (rd_addr), .rd_data (src_rd));
   mdps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_scr (
      .clock (clock), .wr_en (eng_wen.scr), .wr_addr (wr_addr),
      .wr_data (wr_data), .rd_addr (rd_addr), .rd_data (scr_rd));
   mdps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_blr (
      .clock (clock), .wr_en (eng_wen.blr), .wr_addr (wr_addr),
      .wr_data (wr_data), .rd_addr (rd_addr), .rd_data (blr_rd));
   mdps_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_msk (
      .clock (clock), .wr_en (eng_wen.msk), .wr_addr (wr_addr),
      .wr_data (wr_data[0]), .rd_addr (rd_addr), .rd_data (msk_rd));
   mdps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ping (
      .clock (clock), .wr_en (eng_wen.ping), .wr_addr (wr_addr),
      .wr_data (wr_data), .rd_addr (rd_addr), .rd_data (ping_rd));
   mdps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pong (
      .clock (clock), .wr_en (eng_wen.pong), .wr_addr (wr_addr),
      .wr_data (wr_data), .rd_addr (rd_addr), .rd_data (pong_rd));

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams planes into the smoother, starts a run, then reads pixels back and
// compares each response with a predicted plane, over several plane sizes,
// thresholds, strengths and bus idle patterns.
// ----------------------------------------------------------------------------
module tb;
   import mdps_pkg::*;

   localparam int STALL_LIMIT = 1000000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // predicted planes plus the queue of responses still owed by the block
   class plane_scoreboard;
      localparam int PITCH = 512;
      localparam int DEPTH = 512 * 512;

      bit [7:0]    mem [6][DEPTH];
      int unsigned width_reg, height_reg, thresh_reg, hq_reg, str_reg, show_reg;
      bit          result_sel;
      bit [8:0]    owed_q[$];
      int          errors, responses, runs;

      function new();
         width_reg  = 512;
         height_reg = 512;
         thresh_reg = 15;
         hq_reg     = 1;
         str_reg    = 3;
         show_reg   = 0;
         result_sel = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [9:0] val);
         case (idx)
            REG_WIDTH:  width_reg  = val;
            REG_HEIGHT: height_reg = val;
            REG_THRESH: thresh_reg = val[7:0];
            REG_HQ:     hq_reg     = val[0];
            REG_STR:    str_reg    = val[6:0];
            REG_SHOW:   show_reg   = val[0];
            default: ;
         endcase
      endfunction

      function int used_w();
         return width_reg < 3 ? 3 : (width_reg > 512 ? 512 : width_reg);
      endfunction

      function int used_h();
         return height_reg < 3 ? 3 : (height_reg > 512 ? 512 : height_reg);
      endfunction

      function int px(int p, int y, int x);
         return mem[p][y * PITCH + x];
      endfunction

      function int absdiff(int a, int b);
         return a > b ? a - b : b - a;
      endfunction

      // vertical 3-row average, border rows and columns copied
      function void vblur(int si, int di, int w, int h);
         for (int x = 0; x < w; x++) begin
            mem[di][x] = mem[si][x];
            mem[di][(h - 1) * PITCH + x] = mem[si][(h - 1) * PITCH + x];
         end
         for (int y = 1; y + 1 < h; y++) begin
            mem[di][y * PITCH] = mem[si][y * PITCH];
            mem[di][y * PITCH + w - 1] = mem[si][y * PITCH + w - 1];
            for (int x = 1; x + 1 < w; x++)
               mem[di][y * PITCH + x] =
                  8'((px(si, y - 1, x) + px(si, y, x) + px(si, y + 1, x)) / 3);
         end
      endfunction

      // one vertical then one horizontal masked pass
      function void smooth(int si, int di, int w, int h);
         int sum, cnt;
         for (int x = 0; x < w; x++) begin
            mem[MEM_SCR][x] = mem[si][x];
            mem[MEM_SCR][(h - 1) * PITCH + x] = mem[si][(h - 1) * PITCH + x];
         end
         for (int y = 1; y + 1 < h; y++) begin
            mem[MEM_SCR][y * PITCH] = mem[si][y * PITCH];
            mem[MEM_SCR][y * PITCH + w - 1] = mem[si][y * PITCH + w - 1];
            for (int x = 1; x + 1 < w; x++) begin
               if (px(MEM_MSK, y, x) != 0) continue;
               sum = px(si, y, x);
               cnt = 1;
               if (px(MEM_MSK, y - 1, x) == 0) begin sum += px(si, y - 1, x); cnt++; end
               if (px(MEM_MSK, y + 1, x) == 0) begin sum += px(si, y + 1, x); cnt++; end
               mem[MEM_SCR][y * PITCH + x] = 8'(sum / cnt);
            end
         end
         for (int y = 1; y + 1 < h; y++)
            for (int x = 1; x + 1 < w; x++) begin
               if (px(MEM_MSK, y, x) != 0) begin
                  mem[di][y * PITCH + x] = mem[si][y * PITCH + x];
                  continue;
               end
               sum = px(MEM_SCR, y, x);
               cnt = 1;
               if (px(MEM_MSK, y, x - 1) == 0) begin sum += px(MEM_SCR, y, x - 1); cnt++; end
               if (px(MEM_MSK, y, x + 1) == 0) begin sum += px(MEM_SCR, y, x + 1); cnt++; end
               mem[di][y * PITCH + x] = 8'(sum / cnt);
            end
      endfunction

      function void run_filter();
         int w, h, n, si, di;
         bit m;
         w = used_w();
         h = used_h();
         vblur(MEM_SRC, MEM_SCR, w, h);
         vblur(MEM_SCR, MEM_BLR, w, h);
         // diagonal tests on the first blur
         for (int y = 0; y + 1 < h; y++)
            for (int x = 0; x + 1 < w; x++) begin
               m = absdiff(px(MEM_SCR, y, x), px(MEM_SCR, y + 1, x + 1)) >= thresh_reg ||
                   absdiff(px(MEM_SCR, y, x + 1), px(MEM_SCR, y + 1, x)) >= thresh_reg;
               mem[MEM_MSK][y * PITCH + x] = m;
            end
         // vertical and horizontal tests on the second blur
         if (hq_reg != 0) begin
            for (int y = 0; y + 1 < h; y++)
               for (int x = 0; x < w; x++)
                  if (absdiff(px(MEM_BLR, y, x), px(MEM_BLR, y + 1, x)) >= thresh_reg)
                     mem[MEM_MSK][y * PITCH + x] = 1;
            for (int y = 0; y < h; y++)
               for (int x = 0; x + 1 < w; x++)
                  if (absdiff(px(MEM_BLR, y, x), px(MEM_BLR, y, x + 1)) >= thresh_reg)
                     mem[MEM_MSK][y * PITCH + x] = 1;
         end
         // borders are always detail and always copied
         for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y += h - 1) begin
               mem[MEM_MSK][y * PITCH + x] = 1;
               mem[MEM_PING][y * PITCH + x] = mem[MEM_SRC][y * PITCH + x];
               mem[MEM_PONG][y * PITCH + x] = mem[MEM_SRC][y * PITCH + x];
            end
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x += w - 1) begin
               mem[MEM_MSK][y * PITCH + x] = 1;
               mem[MEM_PING][y * PITCH + x] = mem[MEM_SRC][y * PITCH + x];
               mem[MEM_PONG][y * PITCH + x] = mem[MEM_SRC][y * PITCH + x];
            end
         n = str_reg == 0 ? 1 : str_reg;
         for (int k = 0; k < n; k++) begin
            si = k == 0 ? MEM_SRC : ((k & 1) ? MEM_PING : MEM_PONG);
            di = (k & 1) ? MEM_PONG : MEM_PING;
            smooth(si, di, w, h);
         end
         result_sel = (n - 1) & 1;
      endfunction

      // accepted request beat
      function void note_request(logic [31:0] d);
         logic [1:0] mode;
         int         c, r;
         bit [7:0]   v;
         mode = d[1:0];
         c    = d[10:2];
         r    = d[19:11];
         case (mode)
            MODE_LOAD: mem[MEM_SRC][r * PITCH + c] = d[27:20];
            MODE_RUN: begin
               run_filter();
               runs++;
               owed_q.push_back({1'b1, 8'h00});
            end
            MODE_READ: begin
               v = 0;
               if (c < used_w() && r < used_h()) begin
                  if (show_reg != 0)
                     v = px(MEM_MSK, r, c) != 0 ? 8'hff : 8'h00;
                  else
                     v = result_sel ? mem[MEM_PONG][r * PITCH + c]
                                    : mem[MEM_PING][r * PITCH + c];
               end
               owed_q.push_back({1'b0, v});
            end
            default: ;
         endcase
      endfunction

      function void mismatch(string what, int want, int got);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
      endfunction

      // accepted response beat
      function void check_response(logic [15:0] d);
         bit [8:0] want;
         responses++;
         if (owed_q.size() == 0) begin
            mismatch("unexpected response, pixel_out", -1, d[7:0]);
            return;
         end
         want = owed_q.pop_front();
         if (d[7:0] !== want[7:0]) mismatch("pixel_out", want[7:0], d[7:0]);
         if (d[8] !== want[8]) mismatch("status", want[8], d[8]);
      endfunction
   endclass

   typedef struct {
      int unsigned w, h, thr, hq, str, show;
   } plane_cfg_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wr_data = '0;

   plane_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   detail_masked_plane_smoother dut (.*);

   initial forever #5 clock = ~clock;

   // receiver side: random stalls plus the occasional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request beat; called and returns at a falling edge
   task automatic send_beat(logic [1:0] mode, int c, int r, int pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, 8'(pix), 9'(r), 9'(c), mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // sender pauses until every owed response is back, then lets the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic program_regs(plane_cfg_type c);
      int unsigned vals[6];
      vals = '{c.w, c.h, c.thr, c.hq, c.str, c.show};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= 3'(i);
         csr_wr_data <= 10'(vals[i]);
         sb.write_reg(3'(i), 10'(vals[i]));
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic read_batch(int n);
      int c, r;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 8) begin
            c = $urandom_range(sb.used_w() - 1);
            r = $urandom_range(sb.used_h() - 1);
         end else begin
            c = $urandom_range(511);
            r = $urandom_range(511);
         end
         case ($urandom_range(19))
            0:       send_beat(MODE_UNUSED, $urandom_range(511), $urandom_range(511), $urandom);
            1:       send_beat(MODE_LOAD, $urandom_range(511), $urandom_range(511), $urandom);
            default: send_beat(MODE_READ, c, r, $urandom);
         endcase
      end
   endtask

   // load the whole plane in use, run, read back with and without the mask view
   task automatic plane_phase(plane_cfg_type c, int style, int reads, bit hold);
      int w, h, base, v;
      program_regs(c);
      w    = sb.used_w();
      h    = sb.used_h();
      base = $urandom_range(255);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            case (style)
               0:       v = $urandom_range(255);
               1:       v = base + $urandom_range(6) - 3;
               default: v = ((x + y) & 1) ? 255 : 0;
            endcase
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            send_beat(MODE_LOAD, x, y, v);
         end
      if ($urandom_range(3) == 0) send_beat(MODE_UNUSED, $urandom_range(511), 0, 0);
      send_beat(MODE_RUN, $urandom_range(511), $urandom_range(511), $urandom);
      if (hold) hold_cycles = 300;
      read_batch(reads);
      drain();
      c.show = !c.show;
      program_regs(c);
      read_batch(reads / 3 + 1);
      drain();
   endtask

   task automatic set_idling(int k);
      case (k % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
         default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   initial begin
      plane_cfg_type c;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: threshold, quality, strength and size extremes on tiny planes
      c = '{3, 3, 0, 1, 1, 0};      plane_phase(c, 0, 4, 0);
      c = '{4, 3, 255, 0, 0, 0};    plane_phase(c, 2, 4, 0);
      c = '{3, 4, 255, 1, 127, 1};  plane_phase(c, 1, 4, 0);
      c = '{0, 1, 20, 0, 100, 0};   plane_phase(c, 1, 4, 0);

      // random planes, mostly small and flat enough to leave pixels unmasked
      for (int k = 0; k < 18; k++) begin
         set_idling(k);
         c.w    = $urandom_range(3, 8);
         c.h    = $urandom_range(3, 8);
         c.thr  = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(4, 40);
         c.hq   = $urandom_range(1);
         c.str  = $urandom_range(7) == 0 ? $urandom_range(127) : $urandom_range(5);
         c.show = $urandom_range(1);
         plane_phase(c, $urandom_range(9) < 6 ? 1 : $urandom_range(2), 30, k == 6);
      end

      // long and narrow planes, with the short side raised to three
      set_idling(0);
      c = '{64, 1, 12, 1, 2, 0};    plane_phase(c, 1, 12, 0);
      c = '{2, 64, 12, 0, 1, 1};    plane_phase(c, 1, 12, 0);
      c = '{512, 512, 15, 1, 3, 0}; program_regs(c);

      drain();
      $display("covered %0d runs and %0d responses over sizes 3x3 up to 64x3 and 3x64",
               sb.runs, sb.responses);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
